@@ rtl/bct_pkg.sv @@
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants for the commutation timing block: field widths,
// register indexes, reset values and reciprocal constants for the divides.
// ----------------------------------------------------------------------------
package bct_pkg;

   localparam int IntervalWidth = 16;
   localparam int PotWidth      = 10;
   localparam int DutyWidth     = 12;
   localparam int SectorWidth   = 3;
   localparam int AdvanceWidth  = 5;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 12;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PHASE_ADVANCE = 2'd0,
      CSR_MIN_DUTY      = 2'd1,
      CSR_MAX_DUTY      = 2'd2
   } csr_index_type;

   localparam logic [AdvanceWidth-1:0] PhaseAdvanceReset = 5'd10;
   localparam logic [DutyWidth-1:0]    MinDutyReset      = 12'd200;
   localparam logic [DutyWidth-1:0]    MaxDutyReset      = 12'd1500;

   localparam logic [SectorWidth-1:0]  SectorFirst       = 3'd1;
   localparam logic [SectorWidth-1:0]  SectorLast        = 3'd6;

   // floor(n/3) = (n * Div3Mult) >> Div3Shift, exact for n < 2^19
   localparam logic [17:0] Div3Mult       = 18'd174763;
   localparam int          Div3Shift      = 19;
   // floor(n/3) for n < 2^13
   localparam logic [12:0] Div3SmallMult  = 13'd5462;
   localparam int          Div3SmallShift = 14;
   // floor(n/15) for n < 2^20
   localparam logic [20:0] Div15Mult      = 21'd1118482;
   localparam int          Div15Shift     = 24;

   typedef struct packed {
      logic [AdvanceWidth-1:0] phase_advance;
      logic [DutyWidth-1:0]    min_duty;
      logic [DutyWidth-1:0]    max_duty;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic [IntervalWidth-1:0] smoothed;
      logic [DutyWidth-1:0]     duty;
      logic [SectorWidth-1:0]   sector;
   } state_type;

endpackage

@@ rtl/bct_state.sv @@
// ----------------------------------------------------------------------------
// bct_state
// Per-crossing state update: interval average, duty stepping with clamps and
// six-step sector advance, all from the registered input item.
// ----------------------------------------------------------------------------
module bct_state import bct_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     item_valid,
   input  logic [IntervalWidth-1:0] elapsed_count,
   input  logic [PotWidth-1:0]      pot_level,
   input  logic                     duty_update_enable,
   input  cfg_type                  cfg,
   output state_type                state
);

   logic                     valid_ff, valid_in;
   logic [IntervalWidth-1:0] prev_ff, prev_in;
   logic [IntervalWidth-1:0] avg_ff, avg_in;
   logic [DutyWidth-1:0]     duty_ff, duty_in;
   logic [SectorWidth-1:0]   sector_ff, sector_in;

   logic [17:0]              sum;
   logic [35:0]              sum_prod;
   logic [12:0]              min_twice;
   logic [25:0]              min_prod;
   logic [DutyWidth-1:0]     floor_level;
   logic [DutyWidth-1:0]     pot_floor;
   logic [13:0]              pot_triple;
   logic [DutyWidth-1:0]     target;
   logic [DutyWidth-1:0]     stepped;
   logic [DutyWidth-1:0]     clamp_lo;
   logic                     load;

   assign load = advance & item_valid;

   always_comb begin
      sum = {2'b00, avg_ff} + {2'b00, prev_ff} + {2'b00, elapsed_count};
      sum_prod = {18'd0, sum} * {18'd0, Div3Mult};

      min_twice = {cfg.min_duty, 1'b0};
      min_prod = {13'd0, min_twice} * {13'd0, Div3SmallMult};
      floor_level = min_prod[Div3SmallShift +: DutyWidth];
      pot_floor = ({2'b00, pot_level} < floor_level) ? floor_level : {2'b00, pot_level};
      pot_triple = {2'b00, pot_floor} + {1'b0, pot_floor, 1'b0};
      target = pot_triple[12:1];

      if (duty_ff < target) begin
         stepped = duty_ff + 12'd1;
      end else if (duty_ff > target) begin
         stepped = duty_ff - 12'd1;
      end else begin
         stepped = duty_ff;
      end
      clamp_lo = (stepped < cfg.min_duty) ? cfg.min_duty : stepped;

      valid_in = advance ? item_valid : valid_ff;
      prev_in = load ? elapsed_count : prev_ff;
      avg_in = load ? sum_prod[Div3Shift +: IntervalWidth] : avg_ff;
      duty_in = duty_ff;
      if (load && duty_update_enable) begin
         duty_in = (clamp_lo > cfg.max_duty) ? cfg.max_duty : clamp_lo;
      end
      sector_in = sector_ff;
      if (load) begin
         sector_in = (sector_ff >= SectorLast) ? SectorFirst : sector_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         prev_ff   <= '0;
         avg_ff    <= '0;
         duty_ff   <= MinDutyReset;
         sector_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         prev_ff   <= prev_in;
         avg_ff    <= avg_in;
         duty_ff   <= duty_in;
         sector_ff <= sector_in;
      end
   end

   assign state.valid    = valid_ff;
   assign state.smoothed = avg_ff;
   assign state.duty     = duty_ff;
   assign state.sector   = sector_ff;

endmodule

@@ rtl/bct_delay.sv @@
// ----------------------------------------------------------------------------
// bct_delay
// Commutation delay: advance term average*advance/60 in two registered steps,
// subtracted from half the average, clamped to at least one; result register.
// ----------------------------------------------------------------------------
module bct_delay import bct_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  state_type                state,
   input  logic [AdvanceWidth-1:0]  phase_advance,
   output logic                     rsp_valid,
   output logic [IntervalWidth-1:0] rsp_delay_period,
   output logic [IntervalWidth-1:0] rsp_smoothed_period,
   output logic [DutyWidth-1:0]     rsp_duty_value,
   output logic [SectorWidth-1:0]   rsp_sector
);

   logic                     mid_valid_ff, mid_valid_in;
   logic [20:0]              prod_ff, prod_in;
   logic [14:0]              half_ff, half_in;
   logic [IntervalWidth-1:0] mid_smoothed_ff, mid_smoothed_in;
   logic [DutyWidth-1:0]     mid_duty_ff, mid_duty_in;
   logic [SectorWidth-1:0]   mid_sector_ff, mid_sector_in;

   logic                     out_valid_ff, out_valid_in;
   logic [IntervalWidth-1:0] delay_ff, delay_in;
   logic [IntervalWidth-1:0] smoothed_ff, smoothed_in;
   logic [DutyWidth-1:0]     duty_ff, duty_in;
   logic [SectorWidth-1:0]   sector_ff, sector_in;

   logic [39:0]              quot_prod;
   logic [IntervalWidth-1:0] adv_term;
   logic [IntervalWidth-1:0] half_ext;
   logic [IntervalWidth-1:0] diff;

   always_comb begin
      mid_valid_in    = advance ? state.valid : mid_valid_ff;
      prod_in         = advance ? {5'd0, state.smoothed} * {16'd0, phase_advance} : prod_ff;
      half_in         = advance ? state.smoothed[IntervalWidth-1:1] : half_ff;
      mid_smoothed_in = advance ? state.smoothed : mid_smoothed_ff;
      mid_duty_in     = advance ? state.duty : mid_duty_ff;
      mid_sector_in   = advance ? state.sector : mid_sector_ff;

      // divide by 60 as a shift by 2 then a reciprocal multiply for 15
      quot_prod = {21'd0, prod_ff[20:2]} * {19'd0, Div15Mult};
      adv_term  = quot_prod[Div15Shift +: IntervalWidth];
      half_ext  = {1'b0, half_ff};
      diff      = (half_ext > adv_term) ? half_ext - adv_term : '0;

      out_valid_in = advance ? mid_valid_ff : out_valid_ff;
      delay_in     = advance ? ((diff == '0) ? 16'd1 : diff) : delay_ff;
      smoothed_in  = advance ? mid_smoothed_ff : smoothed_ff;
      duty_in      = advance ? mid_duty_ff : duty_ff;
      sector_in    = advance ? mid_sector_ff : sector_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff         <= prod_in;
      half_ff         <= half_in;
      mid_smoothed_ff <= mid_smoothed_in;
      mid_duty_ff     <= mid_duty_in;
      mid_sector_ff   <= mid_sector_in;
      delay_ff        <= delay_in;
      smoothed_ff     <= smoothed_in;
      duty_ff         <= duty_in;
      sector_ff       <= sector_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_delay_period    = delay_ff;
   assign rsp_smoothed_period = smoothed_ff;
   assign rsp_duty_value      = duty_ff;
   assign rsp_sector          = sector_ff;

endmodule

@@ rtl/bldc_commutation_timing.sv @@
// ----------------------------------------------------------------------------
// bldc_commutation_timing
// Sensorless six-step commutation timing: per zero crossing, averages the
// interval, derives the advanced commutation delay, steps the duty, and
// advances the sector.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | elapsed_count, pot_level, enable
//   rsp     | out       | rsp_valid / rsp_ready   | delay, smoothed period, duty, sector
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// one item per cycle while no result waits; a taken item reaches rsp through the pipeline
// the pipeline is input register, state update, advance product, result register
// the whole pipeline holds while a result waits, so req_ready drops only then
// synchronous reset clears valids and puts state and csr registers at their reset values
// csr writes are always taken; an index past the register list is dropped
// ----------------------------------------------------------------------------
module bldc_commutation_timing import bct_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IntervalWidth-1:0] req_elapsed_count,
   input  logic [PotWidth-1:0]      req_pot_level,
   input  logic                     req_duty_update_enable,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IntervalWidth-1:0] rsp_delay_period,
   output logic [IntervalWidth-1:0] rsp_smoothed_period,
   output logic [DutyWidth-1:0]     rsp_duty_value,
   output logic [SectorWidth-1:0]   rsp_sector,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type                  cfg_ff, cfg_in;
   logic                     in_valid_ff, in_valid_in;
   logic [IntervalWidth-1:0] elapsed_ff, elapsed_in;
   logic [PotWidth-1:0]      pot_ff, pot_in;
   logic                     enable_ff, enable_in;
   logic                     advance;
   state_type                state;

   assign advance   = ~rsp_valid | rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_ADVANCE: cfg_in.phase_advance = csr_data[AdvanceWidth-1:0];
            CSR_MIN_DUTY:      cfg_in.min_duty      = csr_data[DutyWidth-1:0];
            CSR_MAX_DUTY:      cfg_in.max_duty      = csr_data[DutyWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end

      in_valid_in = advance ? req_valid : in_valid_ff;
      elapsed_in  = advance ? req_elapsed_count : elapsed_ff;
      pot_in      = advance ? req_pot_level : pot_ff;
      enable_in   = advance ? req_duty_update_enable : enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_advance <= PhaseAdvanceReset;
         cfg_ff.min_duty      <= MinDutyReset;
         cfg_ff.max_duty      <= MaxDutyReset;
         in_valid_ff          <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      pot_ff     <= pot_in;
      enable_ff  <= enable_in;
   end

   bct_state u_state (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .item_valid         (in_valid_ff),
      .elapsed_count      (elapsed_ff),
      .pot_level          (pot_ff),
      .duty_update_enable (enable_ff),
      .cfg                (cfg_ff),
      .state              (state)
   );

   bct_delay u_delay (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .state               (state),
      .phase_advance       (cfg_ff.phase_advance),
      .rsp_valid           (rsp_valid),
      .rsp_delay_period    (rsp_delay_period),
      .rsp_smoothed_period (rsp_smoothed_period),
      .rsp_duty_value      (rsp_duty_value),
      .rsp_sector          (rsp_sector)
   );

endmodule
